[sv/linear_probe_hash_table_macros.svh]
// Assertion macros for the linear probe hash table.
// Assumes signals named clock and reset in the including scope.
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// Property holds at every edge outside reset.
`define LPHT_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("linear_probe_hash_table: check failed");

// Consequence holds in the same cycle as the condition.
`define LPHT_ASSERT_SAME(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("linear_probe_hash_table: check failed");

// Consequence holds in the cycle after the condition.
`define LPHT_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("linear_probe_hash_table: check failed");

`endif

[sv/lpht_pkg.sv]
// Shared types and constants of the linear probe hash table.
// No dependencies.
package lpht_pkg;

   localparam int KEY_W       = 64;
   localparam int VALUE_W     = 64;
   localparam int HASH_W      = 32;
   localparam int REDUCE_BITS = 8;
   localparam int REDUCE_STEPS = HASH_W / REDUCE_BITS;

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_SET    = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [KEY_W-1:0]   key;
      logic [HASH_W-1:0]  key_hash;
      logic [VALUE_W-1:0] new_value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [VALUE_W-1:0] read_value;
      logic               inserted_new;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic             occupied;
      logic             tombstone;
      logic [KEY_W-1:0] key;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_ISSUE,
      ST_PROBE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear_wr;
      logic load_req;
      logic reduce_step;
      logic issue;
      logic probe_step;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic reduce_last;
      logic probe_stop;
   } dp_stat_type;

endpackage

[sv/lpht_ram.sv]
// Generic single write port RAM with registered read.
// No dependencies.
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/lpht_dp.sv]
// Datapath of the linear probe hash table: hash reduction, probe walk,
// slot and value memories, use count and result register. Uses lpht_pkg, lpht_ram.
module lpht_dp #(
   parameter int TABLE_SLOTS = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lpht_pkg::dp_cmd_type cmd,
   output lpht_pkg::dp_stat_type stat,
   input  lpht_pkg::req_type    req_data,
   output lpht_pkg::rsp_type    rsp_data
);

   localparam int IDX_W     = $clog2(TABLE_SLOTS);
   localparam int CNT_W     = $clog2(TABLE_SLOTS + 1);
   localparam int REM_W     = IDX_W + 1;
   localparam int LAST_IDX  = TABLE_SLOTS - 1;
   localparam int LIMIT     = (TABLE_SLOTS * 3) / 4;
   localparam int RED_CNT_W = $clog2(lpht_pkg::REDUCE_STEPS);
   localparam bit SLOTS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);

   lpht_pkg::req_type                  req_ff;
   logic [lpht_pkg::HASH_W-1:0]        hash_ff;
   logic [REM_W-1:0]                   rem_ff;
   logic [REM_W-1:0]                   rem_in;
   logic [REM_W-1:0]                   trial;
   logic [RED_CNT_W-1:0]               red_cnt_ff;
   logic [IDX_W-1:0]                   clear_idx_ff;
   logic [IDX_W-1:0]                   probe_idx_ff;
   logic [IDX_W-1:0]                   probe_cnt_ff;
   logic [IDX_W-1:0]                   tomb_idx_ff;
   logic [IDX_W-1:0]                   where_ff;
   logic                               have_tomb_ff;
   logic                               match_ff;
   logic                               fresh_ff;
   logic                               found_ff;
   logic [lpht_pkg::VALUE_W-1:0]       value_ff;
   logic [CNT_W-1:0]                   used_ff;
   lpht_pkg::rsp_type                  rsp_ff;
   lpht_pkg::rsp_type                  rsp_in;

   logic [IDX_W-1:0]                   start_idx;
   logic [IDX_W-1:0]                   next_idx;
   logic [IDX_W-1:0]                   rd_addr;
   logic                               rd_en;
   lpht_pkg::slot_type                 slot_rd;
   logic [lpht_pkg::SLOT_W-1:0]        slot_rdata;
   logic [lpht_pkg::VALUE_W-1:0]       value_rdata;
   logic                               hit_now;
   logic                               empty_now;
   logic                               tomb_now;
   logic                               last_probe;

   logic                               slot_we;
   logic                               value_we;
   logic                               used_inc;
   lpht_pkg::slot_type                 slot_commit;
   logic                               slot_wr_en;
   logic [IDX_W-1:0]                   slot_wr_addr;
   lpht_pkg::slot_type                 slot_wr_data;
   logic                               full;

   // hash reduction, one byte of the hash per step
   always_comb begin
      rem_in = rem_ff;
      trial  = rem_ff;
      for (int b = 0; b < lpht_pkg::REDUCE_BITS; b++) begin
         trial = {rem_in[REM_W-2:0], hash_ff[lpht_pkg::HASH_W-1-b]};
         if (trial >= REM_W'(TABLE_SLOTS)) begin
            rem_in = trial - REM_W'(TABLE_SLOTS);
         end else begin
            rem_in = trial;
         end
      end
   end

   assign start_idx = SLOTS_POW2 ? req_ff.key_hash[IDX_W-1:0] : rem_ff[IDX_W-1:0];
   assign next_idx  = (probe_idx_ff == IDX_W'(LAST_IDX)) ? '0 : probe_idx_ff + 1'b1;
   assign rd_addr   = cmd.issue ? start_idx : next_idx;
   assign rd_en     = cmd.issue | cmd.probe_step;

   assign slot_rd    = lpht_pkg::slot_type'(slot_rdata);
   assign hit_now    = slot_rd.occupied && (slot_rd.key == req_ff.key);
   assign empty_now  = !slot_rd.occupied && !slot_rd.tombstone;
   assign tomb_now   = !slot_rd.occupied && slot_rd.tombstone;
   assign last_probe = (probe_cnt_ff == IDX_W'(LAST_IDX));

   assign stat.probe_stop  = hit_now | empty_now | last_probe;
   assign stat.clear_last  = (clear_idx_ff == IDX_W'(LAST_IDX));
   assign stat.reduce_last = (red_cnt_ff == RED_CNT_W'(lpht_pkg::REDUCE_STEPS - 1));

   assign full = fresh_ff && (used_ff >= CNT_W'(LIMIT));

   always_comb begin
      rsp_in      = '0;
      slot_we     = 1'b0;
      value_we    = 1'b0;
      used_inc    = 1'b0;
      slot_commit = '0;
      slot_commit.key = req_ff.key;
      unique case (req_ff.cmd)
         lpht_pkg::CMD_LOOKUP: begin
            if (match_ff) begin
               rsp_in.hit        = 1'b1;
               rsp_in.read_value = value_ff;
            end
         end
         lpht_pkg::CMD_SET: begin
            if (match_ff) begin
               rsp_in.hit = 1'b1;
               value_we   = 1'b1;
            end else if (!found_ff || full) begin
               rsp_in.status = 1'b1;
            end else begin
               rsp_in.inserted_new  = 1'b1;
               slot_we              = 1'b1;
               value_we             = 1'b1;
               used_inc             = fresh_ff;
               slot_commit.occupied = 1'b1;
            end
         end
         lpht_pkg::CMD_DELETE: begin
            if (match_ff) begin
               rsp_in.hit            = 1'b1;
               slot_we               = 1'b1;
               slot_commit.tombstone = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign slot_wr_en   = cmd.clear_wr | (cmd.commit & slot_we);
   assign slot_wr_addr = cmd.clear_wr ? clear_idx_ff : where_ff;
   assign slot_wr_data = cmd.clear_wr ? lpht_pkg::slot_type'('0) : slot_commit;

   lpht_ram #(
      .WIDTH (lpht_pkg::SLOT_W),
      .DEPTH (TABLE_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (slot_rdata)
   );

   lpht_ram #(
      .WIDTH (lpht_pkg::VALUE_W),
      .DEPTH (TABLE_SLOTS)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (cmd.commit & value_we),
      .wr_addr (where_ff),
      .wr_data (req_ff.new_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (value_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_idx_ff <= '0;
         red_cnt_ff   <= '0;
         probe_cnt_ff <= '0;
         have_tomb_ff <= 1'b0;
         used_ff      <= '0;
      end else begin
         if (cmd.clear_wr) begin
            clear_idx_ff <= clear_idx_ff + 1'b1;
         end
         if (cmd.load_req) begin
            red_cnt_ff <= '0;
         end else if (cmd.reduce_step) begin
            red_cnt_ff <= red_cnt_ff + 1'b1;
         end
         if (cmd.issue) begin
            probe_cnt_ff <= '0;
            have_tomb_ff <= 1'b0;
         end else if (cmd.probe_step) begin
            probe_cnt_ff <= probe_cnt_ff + 1'b1;
            if (tomb_now && !have_tomb_ff) begin
               have_tomb_ff <= 1'b1;
            end
         end
         if (cmd.commit && used_inc) begin
            used_ff <= used_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff  <= req_data;
         hash_ff <= req_data.key_hash;
         rem_ff  <= '0;
      end else if (cmd.reduce_step) begin
         hash_ff <= hash_ff << lpht_pkg::REDUCE_BITS;
         rem_ff  <= rem_in;
      end
      if (cmd.issue) begin
         probe_idx_ff <= start_idx;
      end else if (cmd.probe_step) begin
         if (tomb_now && !have_tomb_ff) begin
            tomb_idx_ff <= probe_idx_ff;
         end
         if (stat.probe_stop) begin
            match_ff <= hit_now;
            fresh_ff <= empty_now && !have_tomb_ff;
            found_ff <= hit_now | empty_now | tomb_now | have_tomb_ff;
            where_ff <= (hit_now || !have_tomb_ff) ? probe_idx_ff : tomb_idx_ff;
            value_ff <= value_rdata;
         end else begin
            probe_idx_ff <= next_idx;
         end
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

[sv/lpht_ctrl.sv]
// Controller of the linear probe hash table: clearing pass, hash reduction,
// probe and commit sequencing, result valid. Uses lpht_pkg.
module lpht_ctrl #(
   parameter int TABLE_SLOTS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lpht_pkg::dp_cmd_type  cmd,
   input  lpht_pkg::dp_stat_type stat
);

   localparam bit SLOTS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);

   lpht_pkg::state_type state_ff;
   lpht_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lpht_pkg::ST_CLEAR: begin
            if (stat.clear_last) begin
               state_in = lpht_pkg::ST_IDLE;
            end
         end
         lpht_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = SLOTS_POW2 ? lpht_pkg::ST_ISSUE : lpht_pkg::ST_REDUCE;
            end
         end
         lpht_pkg::ST_REDUCE: begin
            if (stat.reduce_last) begin
               state_in = lpht_pkg::ST_ISSUE;
            end
         end
         lpht_pkg::ST_ISSUE: begin
            state_in = lpht_pkg::ST_PROBE;
         end
         lpht_pkg::ST_PROBE: begin
            if (stat.probe_stop) begin
               state_in = lpht_pkg::ST_DONE;
            end
         end
         lpht_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = lpht_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lpht_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         lpht_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         lpht_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         lpht_pkg::ST_REDUCE: begin
            cmd.reduce_step = 1'b1;
         end
         lpht_pkg::ST_ISSUE: begin
            cmd.issue = 1'b1;
         end
         lpht_pkg::ST_PROBE: begin
            cmd.probe_step = 1'b1;
         end
         lpht_pkg::ST_DONE: begin
            cmd.commit = out_free;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = cmd.commit | (rsp_valid_ff & !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpht_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[sv/linear_probe_hash_table.sv]
// Top level of the linear probe hash table: controller plus datapath.
// Uses lpht_pkg, lpht_ctrl, lpht_dp and linear_probe_hash_table_macros.svh.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   lpht_pkg::req_type
//   rsp      out        rsp_valid/rsp_ready   lpht_pkg::rsp_type
//
// After acceptance an item passes the issue, probe and done states; the probe
// walk reads one slot per cycle from the slot memory. Sizes that are not a power
// of two first reduce the hash, one byte per step. After reset a clearing pass of
// all slots runs with req_ready low. A finished result waits in the output register;
// the next item is accepted meanwhile, and its commit holds until that beat is taken.
`include "linear_probe_hash_table_macros.svh"

module linear_probe_hash_table #(
   parameter int TABLE_SLOTS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lpht_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lpht_pkg::rsp_type rsp_data
);

   lpht_pkg::dp_cmd_type  dp_cmd;
   lpht_pkg::dp_stat_type dp_stat;

   lpht_ctrl #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (dp_cmd),
      .stat      (dp_stat)
   );

   lpht_dp #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (dp_cmd),
      .stat     (dp_stat),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   `LPHT_ASSERT_ALWAYS(a_cmd_onehot, $onehot0(dp_cmd))
   `LPHT_ASSERT_SAME(a_commit_free, dp_cmd.commit, !rsp_valid || rsp_ready)
   `LPHT_ASSERT_NEXT(a_commit_shows, dp_cmd.commit, rsp_valid)
   `LPHT_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready)

endmodule
